### rtl/rcf_pkg.sv
// rcf_pkg: shared types, codes and helpers for the RGBA color fader.
// Used by rcf_divider and rgba_color_fader; depends on nothing.
package rcf_pkg;

  localparam int LEVEL_W = 8;
  localparam int PROD_W  = 2 * LEVEL_W;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [PROD_W-1:0]  prod_t;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_FADE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;
  localparam logic [1:0] CH_A = 2'd3;

  localparam level_t THRESHOLD_RESET = 8'd20;

  // floor(x / 255) for any product of two levels
  function automatic level_t div255(input prod_t x);
    prod_t sum;
    begin
      sum = x + prod_t'(1) + (x >> LEVEL_W);
      return sum[PROD_W-1:LEVEL_W];
    end
  endfunction

endpackage

### rtl/rgba_color_fader.sv
// rgba_color_fader: linear RGBA fade controller with alpha-dimmed drive levels.
// Uses rcf_pkg and rcf_divider.
//
// Requests enter on the s_ group: tuser carries the operation (set color,
// start fade, fade tick), tdata the color and the step limit. Every request
// gives one result on the m_ group: three dimmed levels, the fade flag and
// the lights-up flag. The threshold register is written on cfg_valid/cfg_data
// and is always ready. One request is worked on at a time; s_tready is high
// only while the sequencer is idle.
// Set, fade start, ignored codes and ticks while not fading go straight to the
// dimming pass, where the shared 8x8 multiplier does the three dimming products
// one after another. A fade tick while fading first scans the four channels for
// the largest gap, then per channel does one multiply and a pass of the shared
// 8-step divider, then the dimming pass; the multiplies and divides are skipped
// when the color already matches the target.
// A finished result waits in the output register while m_tready is low; the
// next request may be accepted meanwhile but its result holds until the
// register frees. Reset clears the colors to black, the step limit to zero,
// ends any fade and sets the threshold to 20.
module rgba_color_fader (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // red_in, green_in, blue_in, alpha_in, speed_in
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // red_pwm, green_pwm, blue_pwm, fading, lights_up, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MAXD   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_DSTART = 4'd3;
  localparam logic [3:0] ST_DWAIT  = 4'd4;
  localparam logic [3:0] ST_CHECK  = 4'd5;
  localparam logic [3:0] ST_PMUL   = 4'd6;
  localparam logic [3:0] ST_PSTORE = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0]      state;
  logic [1:0]      ch;
  rcf_pkg::level_t cur [4];
  rcf_pkg::level_t tgt [4];
  rcf_pkg::level_t col [4];
  rcf_pkg::level_t pwm [3];
  rcf_pkg::level_t step_limit;
  rcf_pkg::level_t threshold;
  rcf_pkg::level_t maxd;
  rcf_pkg::prod_t  prod;
  logic            fade_active;

  rcf_pkg::level_t gap;
  rcf_pkg::level_t maxd_next;
  rcf_pkg::level_t mul_a;
  rcf_pkg::level_t mul_b;
  rcf_pkg::level_t quo;
  rcf_pkg::level_t step;
  rcf_pkg::level_t approach;
  logic            div_done;
  logic            accept;
  logic            out_free;
  logic            same_in;
  logic            same_cur;
  logic            lights;
  rcf_pkg::level_t chk [4];

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = state == ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  assign col[0] = s_tdata[7:0];
  assign col[1] = s_tdata[15:8];
  assign col[2] = s_tdata[23:16];
  assign col[3] = s_tdata[31:24];

  assign same_in  = col[0] == cur[0] && col[1] == cur[1] &&
                    col[2] == cur[2] && col[3] == cur[3];
  assign same_cur = cur[0] == tgt[0] && cur[1] == tgt[1] &&
                    cur[2] == tgt[2] && cur[3] == tgt[3];

  assign gap       = (cur[ch] >= tgt[ch]) ? cur[ch] - tgt[ch] : tgt[ch] - cur[ch];
  assign maxd_next = (gap > maxd) ? gap : maxd;

  assign mul_a = (state == ST_MUL) ? step_limit : cur[ch];
  assign mul_b = (state == ST_MUL) ? gap : cur[rcf_pkg::CH_A];

  rcf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DSTART),
    .dividend (prod),
    .divisor  (maxd),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    step = (quo > step_limit) ? step_limit : quo;
    if (step == '0) begin
      step = rcf_pkg::level_t'(1);
    end
    if (step >= gap) begin
      approach = tgt[ch];
    end else if (cur[ch] < tgt[ch]) begin
      approach = cur[ch] + step;
    end else begin
      approach = cur[ch] - step;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      chk[i] = fade_active ? tgt[i] : cur[i];
    end
    lights = (chk[rcf_pkg::CH_A] >= threshold) &&
             (chk[rcf_pkg::CH_R] > threshold || chk[rcf_pkg::CH_G] > threshold ||
              chk[rcf_pkg::CH_B] > threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ch          <= '0;
      fade_active <= 1'b0;
      step_limit  <= '0;
      threshold   <= rcf_pkg::THRESHOLD_RESET;
      m_tvalid    <= 1'b0;
      maxd        <= '0;
      for (int i = 0; i < 4; i++) begin
        cur[i] <= '0;
        tgt[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ch    <= '0;
            maxd  <= '0;
            state <= ST_PMUL;
            case (s_tuser)
              rcf_pkg::OP_SET: begin
                for (int i = 0; i < 4; i++) begin
                  cur[i] <= col[i];
                end
              end
              rcf_pkg::OP_FADE: begin
                if (same_in) begin
                  fade_active <= 1'b0;
                end else begin
                  for (int i = 0; i < 4; i++) begin
                    tgt[i] <= col[i];
                  end
                  step_limit  <= s_tdata[39:32];
                  fade_active <= 1'b1;
                end
              end
              rcf_pkg::OP_TICK: begin
                if (fade_active) begin
                  state <= ST_MAXD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MAXD: begin
          maxd <= maxd_next;
          ch   <= ch + 2'd1;
          if (ch == rcf_pkg::CH_A) begin
            state <= (maxd_next == '0) ? ST_CHECK : ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= rcf_pkg::prod_t'(mul_a) * rcf_pkg::prod_t'(mul_b);
          state <= ST_DSTART;
        end
        ST_DSTART: begin
          state <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_done) begin
            cur[ch] <= approach;
            ch      <= ch + 2'd1;
            state   <= (ch == rcf_pkg::CH_A) ? ST_CHECK : ST_MUL;
          end
        end
        ST_CHECK: begin
          if (same_cur) begin
            fade_active <= 1'b0;
          end
          ch    <= '0;
          state <= ST_PMUL;
        end
        ST_PMUL: begin
          prod  <= rcf_pkg::prod_t'(mul_a) * rcf_pkg::prod_t'(mul_b);
          state <= ST_PSTORE;
        end
        ST_PSTORE: begin
          pwm[ch] <= rcf_pkg::div255(prod);
          if (ch == rcf_pkg::CH_B) begin
            state <= ST_OUT;
          end else begin
            ch    <= ch + 2'd1;
            state <= ST_PMUL;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, lights, fade_active, pwm[2], pwm[1], pwm[0]};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/rcf_divider.sv
// rcf_divider: restoring divider, one quotient bit per cycle while running.
// Needs dividend[15:8] < divisor so the quotient fits one level; uses rcf_pkg.
module rcf_divider (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rcf_pkg::prod_t  dividend,
  input  rcf_pkg::level_t divisor,
  output logic            done,
  output rcf_pkg::level_t quotient
);

  rcf_pkg::level_t rem;
  rcf_pkg::level_t quo;
  rcf_pkg::level_t den;
  logic [2:0]      cnt;
  logic            running;

  logic [rcf_pkg::LEVEL_W:0] trial;
  logic                      fits;

  assign trial    = {rem, quo[rcf_pkg::LEVEL_W-1]};
  assign fits     = trial >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem     <= dividend[rcf_pkg::PROD_W-1:rcf_pkg::LEVEL_W];
        quo     <= dividend[rcf_pkg::LEVEL_W-1:0];
        den     <= divisor;
        cnt     <= '1;
        running <= 1'b1;
      end else if (running) begin
        if (fits) begin
          rem <= rcf_pkg::level_t'(trial - {1'b0, den});
        end else begin
          rem <= trial[rcf_pkg::LEVEL_W-1:0];
        end
        quo <= {quo[rcf_pkg::LEVEL_W-2:0], fits};
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

### bench/rgba_color_fader_test.sv
// rgba_color_fader_test: self-checking bench for the RGBA color fader.
// Drives set, fade and tick requests on s_ and checks every m_ result against a
// fade predictor or a fixed row value; depends on rcf_pkg and rgba_color_fader.
`timescale 1ns / 100ps

module rgba_color_fader_test;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 80;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    rcf_pkg::level_t red;
    rcf_pkg::level_t green;
    rcf_pkg::level_t blue;
    logic            fading;
    logic            lights;
  } fader_result_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [39:0]   data;
    logic          typed;
    fader_result_t want;
  } fader_row_t;

  localparam fader_result_t DARK  = '0;
  localparam fader_result_t WHITE = {8'd255, 8'd255, 8'd255, 1'b0, 1'b1};

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // red_in, green_in, blue_in, alpha_in, speed_in
  logic [1:0]  s_tuser;   // operation
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // red_pwm, green_pwm, blue_pwm, fading, lights_up, pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  logic [3:0][7:0] cur_rgba;
  logic [3:0][7:0] tgt_rgba;
  rcf_pkg::level_t step_lim;
  logic            fade_on;
  rcf_pkg::level_t thresh;

  fader_result_t expected_levels[$];
  fader_row_t    directed_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int fault_count;
  int idle_cycles;

  rgba_color_fader u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic fader_result_t advance_fader(input logic [1:0] op,
                                                  input logic [3:0][7:0] col,
                                                  input rcf_pkg::level_t speed);
    fader_result_t   res;
    logic [3:0][7:0] shown;
    int              maxd;
    int              d;
    int              s;
    int              i;
    int              alpha;
    begin
      case (op)
        rcf_pkg::OP_SET: cur_rgba = col;
        rcf_pkg::OP_FADE: begin
          if (col == cur_rgba) begin
            fade_on = 1'b0;
          end else begin
            tgt_rgba = col;
            step_lim = speed;
            fade_on  = 1'b1;
          end
        end
        rcf_pkg::OP_TICK: begin
          if (fade_on) begin
            maxd = 0;
            for (i = 0; i < 4; i++) begin
              d = (cur_rgba[i] >= tgt_rgba[i]) ? int'(cur_rgba[i]) - int'(tgt_rgba[i])
                                               : int'(tgt_rgba[i]) - int'(cur_rgba[i]);
              if (d > maxd) maxd = d;
            end
            if (maxd != 0) begin
              for (i = 0; i < 4; i++) begin
                d = (cur_rgba[i] >= tgt_rgba[i]) ? int'(cur_rgba[i]) - int'(tgt_rgba[i])
                                                 : int'(tgt_rgba[i]) - int'(cur_rgba[i]);
                s = (int'(step_lim) * d) / maxd;
                if (s > int'(step_lim)) s = int'(step_lim);
                if (s < 1) s = 1;
                if (cur_rgba[i] < tgt_rgba[i]) begin
                  cur_rgba[i] = (int'(cur_rgba[i]) + s > int'(tgt_rgba[i])) ?
                                tgt_rgba[i] : rcf_pkg::level_t'(int'(cur_rgba[i]) + s);
                end else if (cur_rgba[i] > tgt_rgba[i]) begin
                  cur_rgba[i] = (int'(cur_rgba[i]) < int'(tgt_rgba[i]) + s) ?
                                tgt_rgba[i] : rcf_pkg::level_t'(int'(cur_rgba[i]) - s);
                end
              end
            end
            if (cur_rgba == tgt_rgba) fade_on = 1'b0;
          end
        end
        default: ;
      endcase
      alpha      = int'(cur_rgba[rcf_pkg::CH_A]);
      res.red    = rcf_pkg::level_t'((int'(cur_rgba[rcf_pkg::CH_R]) * alpha) / 255);
      res.green  = rcf_pkg::level_t'((int'(cur_rgba[rcf_pkg::CH_G]) * alpha) / 255);
      res.blue   = rcf_pkg::level_t'((int'(cur_rgba[rcf_pkg::CH_B]) * alpha) / 255);
      res.fading = fade_on;
      shown      = fade_on ? tgt_rgba : cur_rgba;
      res.lights = (shown[rcf_pkg::CH_A] >= thresh) &&
                   (shown[rcf_pkg::CH_R] > thresh || shown[rcf_pkg::CH_G] > thresh ||
                    shown[rcf_pkg::CH_B] > thresh);
      return res;
    end
  endfunction

  function automatic fader_row_t mk_row(input logic [1:0] op, input int r, input int g,
                                        input int b, input int a, input int spd,
                                        input logic typed, input fader_result_t want);
    fader_row_t row;
    begin
      row.op    = op;
      row.data  = {rcf_pkg::level_t'(spd), rcf_pkg::level_t'(a), rcf_pkg::level_t'(b),
                   rcf_pkg::level_t'(g), rcf_pkg::level_t'(r)};
      row.typed = typed;
      row.want  = want;
      return row;
    end
  endfunction

  function automatic rcf_pkg::level_t pick_level();
    int r;
    begin
      r = $urandom_range(9);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      return rcf_pkg::level_t'($urandom_range(255));
    end
  endfunction

  function automatic rcf_pkg::level_t pick_speed();
    int r;
    begin
      r = $urandom_range(9);
      if (r < 4) return rcf_pkg::level_t'($urandom_range(6));
      if (r == 4) return 8'd255;
      return rcf_pkg::level_t'($urandom_range(255));
    end
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [39:0] data,
                              input logic typed, input fader_result_t want);
    fader_result_t pred;
    begin
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tuser  <= op;
      s_tdata  <= data;
      do @(posedge clk); while (!s_tready);
      pred = advance_fader(op, data[31:0], data[39:32]);
      expected_levels.push_back(typed ? want : pred);
    end
  endtask

  task automatic random_request();
    logic [1:0]      op;
    logic [3:0][7:0] col;
    rcf_pkg::level_t spd;
    int              r;
    begin
      r   = $urandom_range(99);
      col = {pick_level(), pick_level(), pick_level(), pick_level()};
      spd = pick_speed();
      if (r < 15) begin
        op = rcf_pkg::OP_SET;
        if (fade_on && $urandom_range(9) < 3) col = tgt_rgba;
      end else if (r < 35) begin
        op = rcf_pkg::OP_FADE;
      end else if (r < 40) begin
        op  = rcf_pkg::OP_FADE;
        col = cur_rgba;
      end else if (r < 45) begin
        op = OP_NONE;
      end else begin
        op = rcf_pkg::OP_TICK;
      end
      send_request(op, {spd, col}, 1'b0, DARK);
    end
  endtask

  task automatic drain_results();
    begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_threshold(input rcf_pkg::level_t value);
    begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= value;
      do @(posedge clk); while (!cfg_ready);
      thresh = value;
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    fader_result_t want;
    fader_result_t got;
    got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[24], m_tdata[25]};
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (m_tvalid && m_tready) begin
      if (expected_levels.size() == 0) begin
        fault_count = fault_count + 1;
        if (fault_count <= REPORT_LIMIT)
          $display("unexpected result: pwm %0d %0d %0d fading %0b lights %0b",
                   got.red, got.green, got.blue, got.fading, got.lights);
      end else begin
        want = expected_levels.pop_front();
        if (got.red != want.red || got.green != want.green || got.blue != want.blue ||
            got.fading != want.fading || got.lights != want.lights) begin
          fault_count = fault_count + 1;
          if (fault_count <= REPORT_LIMIT)
            $display("mismatch: expected pwm %0d %0d %0d fading %0b lights %0b,",
                     want.red, want.green, want.blue, want.fading, want.lights,
                     " got %0d %0d %0d %0b %0b",
                     got.red, got.green, got.blue, got.fading, got.lights);
        end
      end
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("rgba_color_fader test failed");
      $finish;
    end
  end

  initial begin
    rcf_pkg::level_t settings[5];
    int              ph;
    int              n;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = rcf_pkg::OP_SET;
    m_tready       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    cur_rgba       = '0;
    tgt_rgba       = '0;
    step_lim       = '0;
    fade_on        = 1'b0;
    thresh         = rcf_pkg::THRESHOLD_RESET;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    fault_count    = 0;
    idle_cycles    = 0;

    directed_rows.push_back(mk_row(rcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b1, DARK));
    directed_rows.push_back(mk_row(OP_NONE, 255, 255, 255, 255, 255, 1'b1, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_SET, 255, 255, 255, 255, 0, 1'b1, WHITE));
    directed_rows.push_back(mk_row(rcf_pkg::OP_SET, 0, 0, 0, 0, 255, 1'b1, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_FADE, 0, 0, 0, 0, 9, 1'b1, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_FADE, 255, 128, 0, 255, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_TICK, 255, 255, 255, 255, 255, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_FADE, 200, 10, 100, 255, 255, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_FADE, 20, 30, 40, 21, 3, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_SET, 50, 50, 50, 50, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_FADE, 10, 20, 30, 40, 1, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_SET, 10, 20, 30, 40, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_FADE, 0, 255, 0, 255, 255, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_SET, 255, 0, 255, 20, 0, 1'b0, DARK));
    directed_rows.push_back(mk_row(rcf_pkg::OP_FADE, 255, 0, 255, 20, 128, 1'b0, DARK));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < directed_rows.size(); n++)
      send_request(directed_rows[n].op, directed_rows[n].data,
                   directed_rows[n].typed, directed_rows[n].want);
    drain_results();

    settings[0] = 8'd255;
    settings[1] = 8'd0;
    settings[2] = rcf_pkg::level_t'($urandom_range(255));
    settings[3] = 8'd1;
    settings[4] = rcf_pkg::THRESHOLD_RESET;
    for (ph = 0; ph < 5; ph++) begin
      write_threshold(settings[ph]);
      case (ph)
        1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
        3:       begin send_idle_pct = 15; recv_stall_pct = 15; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 4 && (n == 5 || n == 45)) hold_req = 1'b1;
        random_request();
      end
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (fault_count == 0) begin
      $display("rgba_color_fader test passed");
    end else begin
      $display("rgba_color_fader test failed");
    end
    $finish;
  end

endmodule
